>>> rtl/core/shabs_pkg.sv
// Shared types, constants and tables of the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package shabs_pkg;

   typedef logic [31:0] word_type;

   // Request kinds carried on req_tuser
   localparam logic OpAppend = 1'b0;
   localparam logic OpFinish = 1'b1;

   localparam logic [7:0] PadMarker = 8'h80;
   localparam logic [5:0] LastLenPos = 6'd55;   // last 0x80 position that leaves room for length
   localparam logic [5:0] LenStart = 6'd56;
   localparam logic [5:0] LastRound = 6'd63;
   localparam logic [5:0] LastByte = 6'd63;
   localparam logic [2:0] LastWord = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ACCUM,
      ST_EMIT
   } state_type;

   // Message schedule control
   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] byte_val;
   } sch_ctl_type;

   // Round unit control
   typedef struct packed {
      logic       load;
      logic       step;
      logic       accum;
      logic       init;
      logic [5:0] rnd;
      logic [2:0] sel;
   } rnd_ctl_type;

   localparam word_type InitChain [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type RoundK [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

>>> rtl/core/shabs_sched.sv
// Block buffer and message schedule: a 16-word shift line fed by bytes or by expansion.
`timescale 1ns / 1ps

module shabs_sched (
   input  logic                    clock,
   input  shabs_pkg::sch_ctl_type  ctl,
   output shabs_pkg::word_type     w_top
);

   logic [511:0] win_ff;
   logic [511:0] win_in;
   shabs_pkg::word_type w0, w1, w9, w14, w_new;

   function automatic shabs_pkg::word_type small_sigma0(input shabs_pkg::word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic shabs_pkg::word_type small_sigma1(input shabs_pkg::word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // word j of the window sits at [511-32*j -: 32]; word 0 is the current round's word
   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];

   assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
   assign w_top = w0;

   always_comb begin
      win_in = win_ff;
      if (ctl.shift_byte) begin
         win_in = {win_ff[503:0], ctl.byte_val};
      end else if (ctl.shift_word) begin
         win_in = {win_ff[479:0], w_new};
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

>>> rtl/core/shabs_round.sv
// Shared compression round unit with working variables and chaining words.
`timescale 1ns / 1ps

module shabs_round (
   input  logic                    clock,
   input  logic                    reset,
   input  shabs_pkg::rnd_ctl_type  ctl,
   input  shabs_pkg::word_type     w_in,
   output shabs_pkg::word_type     chain_word
);

   shabs_pkg::word_type var_ff   [0:7];
   shabs_pkg::word_type var_in   [0:7];
   shabs_pkg::word_type chain_ff [0:7];
   shabs_pkg::word_type chain_in [0:7];
   shabs_pkg::word_type t1, t2, ch, maj;

   function automatic shabs_pkg::word_type big_sigma0(input shabs_pkg::word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic shabs_pkg::word_type big_sigma1(input shabs_pkg::word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + big_sigma1(var_ff[4]) + ch + shabs_pkg::RoundK[ctl.rnd] + w_in;
   assign t2  = big_sigma0(var_ff[0]) + maj;

   assign chain_word = chain_ff[ctl.sel];

   always_comb begin
      var_in   = var_ff;
      chain_in = chain_ff;
      if (ctl.load) begin
         var_in = chain_ff;
      end else if (ctl.step) begin
         var_in[0] = t1 + t2;
         var_in[1] = var_ff[0];
         var_in[2] = var_ff[1];
         var_in[3] = var_ff[2];
         var_in[4] = var_ff[3] + t1;
         var_in[5] = var_ff[4];
         var_in[6] = var_ff[5];
         var_in[7] = var_ff[6];
      end
      if (ctl.init) begin
         chain_in = shabs_pkg::InitChain;
      end else if (ctl.accum) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + var_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      var_ff <= var_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= shabs_pkg::InitChain;
      end else begin
         chain_ff <= chain_in;
      end
   end

endmodule

>>> rtl/core/sha256_byte_stream_hasher_core.sv
// Top level of the SHA-256 byte stream hasher: sequencer, padding and result port.
`timescale 1ns / 1ps

// Channel   Dir  Payload                              Transfer
// req_      in   tuser=op (0 append, 1 finish),       req_tvalid & req_tready
//                tdata=data_byte[7:0]
// rsp_      out  tdata=digest_word[31:0],             rsp_tvalid & rsp_tready
//                tlast=last_word
//
// Append shifts its byte into the block; the 64th byte of a block adds the rounds
// and an accumulate step, all in the single shared round unit.
// Finish shifts padding and length in one byte a cycle, runs one or two
// compressions, then offers 8 digest words, one a transfer.
// req_tready is high only while the sequencer is idle; rsp_ stalls hold the word.
// Synchronous active-high reset restores the initial chaining values and clears counts.

module sha256_byte_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] digest_word
   output logic        rsp_tlast
);

   shabs_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;      // bytes held in the current block
   logic [60:0] count_ff, count_in;    // message length in bytes
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;        // digest word being offered
   logic        fin_ff, fin_in;        // finishing a message
   logic        len_ok_ff, len_ok_in;  // length may go into this block
   logic        first_ff, first_in;    // 0x80 marker still to shift in

   logic [63:0] len_bits;
   logic        req_xfer, rsp_xfer;

   shabs_pkg::sch_ctl_type sch_ctl;
   shabs_pkg::rnd_ctl_type rnd_ctl;
   shabs_pkg::word_type    w_top;

   assign len_bits = {count_ff, 3'b000};
   assign req_xfer = req_tvalid & req_tready;
   assign rsp_xfer = rsp_tvalid & rsp_tready;
   assign rsp_tlast = (idx_ff == shabs_pkg::LastWord);

   shabs_sched u_sched (
      .clock (clock),
      .ctl   (sch_ctl),
      .w_top (w_top)
   );

   shabs_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctl        (rnd_ctl),
      .w_in       (w_top),
      .chain_word (rsp_tdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= shabs_pkg::ST_IDLE;
         fill_ff   <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         fin_ff    <= 1'b0;
         len_ok_ff <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         fin_ff    <= fin_in;
         len_ok_ff <= len_ok_in;
         first_ff  <= first_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      fin_in    = fin_ff;
      len_ok_in = len_ok_ff;
      first_in  = first_ff;

      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      sch_ctl = '0;
      rnd_ctl = '0;
      rnd_ctl.rnd = rnd_ff;
      rnd_ctl.sel = idx_ff;

      case (state_ff)
         shabs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               if (req_tuser == shabs_pkg::OpFinish) begin
                  fin_in    = 1'b1;
                  first_in  = 1'b1;
                  len_ok_in = (fill_ff <= shabs_pkg::LastLenPos);
                  state_in  = shabs_pkg::ST_PAD;
               end else begin
                  sch_ctl.shift_byte = 1'b1;
                  sch_ctl.byte_val   = req_tdata;
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
                  if (fill_ff == shabs_pkg::LastByte) begin
                     rnd_ctl.load = 1'b1;
                     rnd_in   = '0;
                     state_in = shabs_pkg::ST_ROUND;
                  end
               end
            end
         end

         shabs_pkg::ST_PAD: begin
            sch_ctl.shift_byte = 1'b1;
            if (first_ff) begin
               sch_ctl.byte_val = shabs_pkg::PadMarker;
            end else if (len_ok_ff && (fill_ff >= shabs_pkg::LenStart)) begin
               // length goes out most significant byte first
               sch_ctl.byte_val = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
            end else begin
               sch_ctl.byte_val = 8'h00;
            end
            first_in = 1'b0;
            fill_in  = fill_ff + 6'd1;
            if (fill_ff == shabs_pkg::LastByte) begin
               rnd_ctl.load = 1'b1;
               rnd_in   = '0;
               state_in = shabs_pkg::ST_ROUND;
            end
         end

         shabs_pkg::ST_ROUND: begin
            rnd_ctl.step       = 1'b1;
            sch_ctl.shift_word = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == shabs_pkg::LastRound) begin
               state_in = shabs_pkg::ST_ACCUM;
            end
         end

         shabs_pkg::ST_ACCUM: begin
            rnd_ctl.accum = 1'b1;
            if (!fin_ff) begin
               state_in = shabs_pkg::ST_IDLE;
            end else if (len_ok_ff) begin
               idx_in   = '0;
               state_in = shabs_pkg::ST_EMIT;
            end else begin
               // marker spilled past the length field: one more block of fill
               len_ok_in = 1'b1;
               state_in  = shabs_pkg::ST_PAD;
            end
         end

         shabs_pkg::ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_xfer) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == shabs_pkg::LastWord) begin
                  rnd_ctl.init = 1'b1;
                  count_in  = '0;
                  fill_in   = '0;
                  fin_in    = 1'b0;
                  len_ok_in = 1'b0;
                  state_in  = shabs_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = shabs_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_block_full_starts_rounds: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_tuser == shabs_pkg::OpAppend) && (fill_ff == shabs_pkg::LastByte))
      |=> (state_ff == shabs_pkg::ST_ROUND) && (rnd_ff == 6'd0))
      else $error("full block did not start compression");

   a_rounds_end_in_accum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == shabs_pkg::ST_ROUND) && (rnd_ff == shabs_pkg::LastRound)
      |=> (state_ff == shabs_pkg::ST_ACCUM))
      else $error("round count overran");

   a_last_word_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast)
      |=> (state_ff == shabs_pkg::ST_IDLE) && (fill_ff == 6'd0) && (count_ff == 61'd0))
      else $error("message state not cleared after digest");

   a_emit_only_when_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fin_ff && len_ok_ff && (fill_ff == 6'd0)))
      else $error("digest offered before final block");

   a_pad_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == shabs_pkg::ST_PAD) |-> fin_ff)
      else $error("padding outside of finish");
`endif

endmodule

>>> tb/sv/sha256_byte_stream_hasher_core_tb.sv
// Testbench of the SHA-256 byte stream hasher: random messages, digest prediction, word checks.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_core_tb;

   localparam int ClockHalf = 4;
   localparam int ResetCycles = 3;
   localparam int MaxGap = 18;
   localparam int RandomItems = 280;
   localparam int CycleLimit = 400000;
   localparam int TailCycles = 200;     // covers a trailing compression

   typedef struct packed {
      shabs_pkg::word_type word;
      logic                last;
   } digest_beat_type;

   // Tracks the hash state of the message in flight and the digest words still owed.
   class sha256_digest_scoreboard;
      shabs_pkg::word_type chain[8];
      logic [7:0]          msg_block[64];
      logic [5:0]          fill;
      logic [60:0]         msg_len;
      digest_beat_type     digest_due[$];
      int                  mismatches;

      function new();
         mismatches = 0;
         foreach (msg_block[i]) msg_block[i] = '0;
         restart_message();
      endfunction

      function void restart_message();
         foreach (chain[i]) chain[i] = shabs_pkg::InitChain[i];
         fill = '0;
         msg_len = '0;
      endfunction

      function int words_outstanding();
         return digest_due.size();
      endfunction

      function shabs_pkg::word_type rotr(shabs_pkg::word_type x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         shabs_pkg::word_type w[64];
         shabs_pkg::word_type a, b, c, d, e, f, g, h, t1, t2, s0, s1;
         for (int i = 0; i < 16; i++) begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
         end
         for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + shabs_pkg::RoundK[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // Called once per accepted request transfer.
      function void note_request(logic op, logic [7:0] data);
         int         pos;
         logic [63:0] bit_len;
         digest_beat_type beat;
         if (op == shabs_pkg::OpAppend) begin
            msg_block[fill] = data;
            msg_len = msg_len + 1'b1;
            fill = fill + 1'b1;
            if (fill == '0) compress_block();
         end else begin
            pos = int'(fill);
            msg_block[pos] = shabs_pkg::PadMarker;
            // no room left for the length: pad out and take an extra block
            if (fill > shabs_pkg::LastLenPos) begin
               for (int j = pos + 1; j < 64; j++) msg_block[j] = '0;
               compress_block();
               pos = 0;
            end else begin
               pos = pos + 1;
            end
            for (int j = pos; j < int'(shabs_pkg::LenStart); j++) msg_block[j] = '0;
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
               msg_block[int'(shabs_pkg::LenStart) + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
               beat.word = chain[i];
               beat.last = (i == int'(shabs_pkg::LastWord));
               digest_due.push_back(beat);
            end
            restart_message();
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("ERROR at %0t: %s", $realtime, what);
      endtask

      // Called once per accepted result transfer.
      task check_digest_word(shabs_pkg::word_type word, logic last);
         digest_beat_type due;
         if (digest_due.size() == 0) begin
            report_mismatch($sformatf("digest word %08h with nothing pending", word));
         end else begin
            due = digest_due.pop_front();
            if (word !== due.word)
               report_mismatch($sformatf("digest word %08h, predicted %08h", word, due.word));
            if (last !== due.last)
               report_mismatch($sformatf("tlast %b, predicted %b (word %08h)",
                                         last, due.last, due.word));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   sha256_digest_scoreboard sb = new();
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  req_burst = 0;
   bit  rsp_burst = 0;

   sha256_byte_stream_hasher_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Gap before the next transfer; a burst flag toggles now and then so that
   // long back-to-back stretches occur as well.
   function automatic int draw_gap(ref bit burst);
      if ($urandom_range(0, 11) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, MaxGap);
   endfunction

   // Valid stays high across back-to-back transfers; it drops only ahead of a gap.
   task automatic send_item(logic op, logic [7:0] data);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, data);
      items_sent++;
   endtask

   task automatic wait_digest_drained();
      while (sb.words_outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_item(shabs_pkg::OpAppend, 8'($urandom_range(0, 255)));
      send_item(shabs_pkg::OpFinish, 8'($urandom_range(0, 255)));
   endtask

   // Result side: random stalls, one check per transfer.
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_digest_word(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      int len;
      int boundary_len[5];
      boundary_len = '{55, 56, 63, 64, 65};
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= shabs_pkg::OpAppend;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // empty message, data byte on finish must be ignored
      send_item(shabs_pkg::OpFinish, 8'hff);
      wait_digest_drained();
      // second empty message right after a finish
      send_item(shabs_pkg::OpFinish, 8'h00);
      // extreme byte values
      send_item(shabs_pkg::OpAppend, 8'h00);
      send_item(shabs_pkg::OpAppend, 8'hff);
      send_item(shabs_pkg::OpFinish, 8'h00);
      // "abc"
      send_item(shabs_pkg::OpAppend, 8'h61);
      send_item(shabs_pkg::OpAppend, 8'h62);
      send_item(shabs_pkg::OpAppend, 8'h63);
      send_item(shabs_pkg::OpFinish, 8'h5a);
      // single-bit-set and single-bit-clear patterns
      send_item(shabs_pkg::OpAppend, 8'h80);
      send_item(shabs_pkg::OpAppend, 8'h7f);
      send_item(shabs_pkg::OpAppend, 8'h01);
      send_item(shabs_pkg::OpAppend, 8'hfe);
      send_item(shabs_pkg::OpFinish, 8'hff);

      // Mostly short messages; the rest sit on the padding boundaries where the
      // length no longer fits (55/56) and where a full block closes (63/64/65).
      items_sent = 0;
      while (items_sent < RandomItems) begin
         if ($urandom_range(0, 9) < 6)
            len = $urandom_range(0, 12);
         else
            len = boundary_len[$urandom_range(0, 4)];
         send_message(len);
         if ($urandom_range(0, 3) == 0) wait_digest_drained();
      end

      req_tvalid <= 1'b0;
      wait_digest_drained();
      repeat (TailCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
